// ===== src/tsa_pkg.sv =====
// ----------------------------------------------------------------------------
// TLS slot allocator package
// Request modes, status codes and default sizes shared by the allocator.
// ----------------------------------------------------------------------------
package tsa_pkg;

    localparam int SLOTS_DEF   = 64;
    localparam int THREADS_DEF = 16;

    localparam int MODE_W   = 2;
    localparam int SLOT_W   = 8;
    localparam int THREAD_W = 4;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int GRANT_W  = 6;

    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SET   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_GET   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK            = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_RESOURCES  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_BOUNDS = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_IN_USE    = 2'd3;

endpackage

// ===== src/tls_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// TLS slot allocator
// Bitmap slot allocator with a per-thread, per-slot value store in one
// synchronous memory. Alloc claims the lowest free slot, free/set/get check it.
// ----------------------------------------------------------------------------
// Result is registered and valid in the cycle after the request is accepted.
// Throughput: one request per cycle while o_stall is low; the map update, the
//   lowest-free-slot search and the store access all complete in the accept cycle.
// Reset: map clears at once; the value store is then zeroed by a sweep over all
//   min(THREADS,16) * 2**clog2(SLOTS) entries (1024 by default), o_stall high.
module tls_slot_allocator #(
    parameter int SLOTS   = tsa_pkg::SLOTS_DEF,
    parameter int THREADS = tsa_pkg::THREADS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [tsa_pkg::MODE_W-1:0]    i_mode,
    input  logic [tsa_pkg::SLOT_W-1:0]    i_slot,
    input  logic [tsa_pkg::THREAD_W-1:0]  i_thread,
    input  logic [tsa_pkg::VALUE_W-1:0]   i_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [tsa_pkg::STATUS_W-1:0]  o_status,
    output logic [tsa_pkg::GRANT_W-1:0]   o_granted_slot,
    output logic [tsa_pkg::VALUE_W-1:0]   o_read_value
);

    localparam int SW    = $clog2(SLOTS);
    localparam int TR    = (THREADS < (1 << tsa_pkg::THREAD_W)) ? THREADS
                                                                : (1 << tsa_pkg::THREAD_W);
    localparam int DEPTH = TR * (1 << SW);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [SLOTS-1:0]                 r_map;
    logic [SLOTS-1:0]                 n_map;
    logic                             r_clr_active;
    logic [AW-1:0]                    r_clr_addr;
    logic                             r_out_valid;
    logic [tsa_pkg::STATUS_W-1:0]     r_status;
    logic [SW-1:0]                    r_grant;
    logic                             r_get_ok;
    logic [tsa_pkg::VALUE_W-1:0]      r_rd_data;
    logic [tsa_pkg::VALUE_W-1:0]      r_store [DEPTH];

    logic                             acc;
    logic                             map_full;
    logic [SLOTS-1:0]                 low_free;
    logic [SW-1:0]                    grant_idx;
    logic [SW-1:0]                    slot_idx;
    logic                             slot_in_range;
    logic                             slot_in_use;
    logic                             thread_ok;
    logic [AW-1:0]                    req_addr;
    logic [tsa_pkg::STATUS_W-1:0]     n_status;
    logic                             set_ok;
    logic                             get_ok;
    logic                             mem_we;
    logic [AW-1:0]                    mem_waddr;
    logic [tsa_pkg::VALUE_W-1:0]      mem_wdata;

    assign o_stall = r_clr_active || (r_out_valid && i_stall);
    assign acc     = i_valid && !o_stall;

    // lowest clear bit, isolated, then encoded
    assign map_full = &r_map;
    assign low_free = ~r_map & (r_map + SLOTS'(1));

    always_comb begin
        grant_idx = '0;
        for (int b = 0; b < SW; b++) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (((i >> b) & 1) == 1) begin
                    grant_idx[b] = grant_idx[b] | low_free[i];
                end
            end
        end
    end

    assign slot_idx      = i_slot[SW-1:0];
    assign slot_in_range = i_slot < tsa_pkg::SLOT_W'(SLOTS);
    assign slot_in_use   = slot_in_range && r_map[slot_idx];
    assign thread_ok     = {5'b0, i_thread} < 9'(THREADS);
    assign req_addr      = AW'({i_thread, slot_idx});

    always_comb begin
        n_map    = r_map;
        n_status = tsa_pkg::ST_OK;
        set_ok   = 1'b0;
        get_ok   = 1'b0;
        if (i_mode == tsa_pkg::MODE_ALLOC) begin
            if (map_full) begin
                n_status = tsa_pkg::ST_NO_RESOURCES;
            end else begin
                n_map = r_map | low_free;
            end
        end else if (!slot_in_range) begin
            n_status = tsa_pkg::ST_OUT_OF_BOUNDS;
        end else if (!slot_in_use) begin
            n_status = tsa_pkg::ST_NOT_IN_USE;
        end else if (i_mode == tsa_pkg::MODE_FREE) begin
            n_map = r_map & ~(SLOTS'(1) << slot_idx);
        end else if (!thread_ok) begin
            n_status = tsa_pkg::ST_OUT_OF_BOUNDS;
        end else if (i_mode == tsa_pkg::MODE_SET) begin
            set_ok = 1'b1;
        end else begin
            get_ok = 1'b1;
        end
    end

    assign mem_we    = r_clr_active || (acc && set_ok);
    assign mem_waddr = r_clr_active ? r_clr_addr : req_addr;
    assign mem_wdata = r_clr_active ? '0 : i_value;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_waddr] <= mem_wdata;
        end
        if (acc && get_ok) begin
            r_rd_data <= r_store[req_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map        <= '0;
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_clr_active) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    r_clr_active <= 1'b0;
                end
            end
            if (acc) begin
                r_map       <= n_map;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_status <= n_status;
            r_grant  <= (i_mode == tsa_pkg::MODE_ALLOC && !map_full) ? grant_idx : '0;
            r_get_ok <= get_ok;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_granted_slot = tsa_pkg::GRANT_W'(r_grant);
    assign o_read_value   = r_get_ok ? r_rd_data : '0;

    a_fail_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != tsa_pkg::ST_OK)
            |-> (o_granted_slot == '0 && o_read_value == '0))
        else $error("failed request carries nonzero result fields");

    a_alloc_sets_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_mode == tsa_pkg::MODE_ALLOC && !map_full)
            |=> (r_map[$past(grant_idx)] && !$past(r_map[grant_idx])))
        else $error("alloc did not claim a previously free slot");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> (!acc && !r_out_valid))
        else $error("request taken during store clearing sweep");

    a_grant_only_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_mode != tsa_pkg::MODE_ALLOC) |=> (r_grant == '0))
        else $error("grant index set by non-alloc request");

endmodule
